@@ rtl/icd_pkg.sv @@
// Package for the interlace comb detector: widths, register codes, job and state types.
// No dependencies; the top, icd_front, icd_queue and icd_back use it.
`timescale 1ns / 1ps
package icd_pkg;

  localparam int MAX_ROW_BYTES = 8192;
  localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
  localparam int COL_W         = 14;
  localparam int ROW_W         = 13;
  localparam int CNT_W         = 25;
  localparam int SUM_W         = CNT_W + 1;
  localparam int AREA_W        = COL_W + ROW_W;
  localparam int NUM_W         = SUM_W + 10;
  localparam int SCORE_W       = 10;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = QPTR_W + 1;

  localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [ROW_W-1:0]   ROW_SAT     = ROW_W'(4096);
  localparam logic [SCORE_W-1:0] SCORE_MAX   = SCORE_W'(1000);

  localparam logic [COL_W-1:0]   ROW_BYTES_RST    = COL_W'(720);
  localparam logic [ROW_W-1:0]   ROW_COUNT_RST    = ROW_W'(576);
  localparam logic [7:0]         LUMA_EQ_RST      = 8'd10;
  localparam logic [7:0]         LUMA_DF_RST      = 8'd30;
  localparam logic [SCORE_W-1:0] LUMA_LIM_RST     = SCORE_W'(9);
  localparam logic [7:0]         CHROMA_EQ_RST    = 8'd5;
  localparam logic [7:0]         CHROMA_DF_RST    = 8'd15;
  localparam logic [SCORE_W-1:0] CHROMA_LIM_RST   = SCORE_W'(4);

  typedef enum logic [3:0] {
    REG_ROW_BYTES   = 4'd0,
    REG_ROW_COUNT   = 4'd1,
    REG_LUMA_EQ     = 4'd2,
    REG_LUMA_DF     = 4'd3,
    REG_LUMA_LIM    = 4'd4,
    REG_CHROMA_EQ   = 4'd5,
    REG_CHROMA_DF   = 4'd6,
    REG_CHROMA_LIM  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]   first;
    logic [CNT_W-1:0]   second;
    logic [AREA_W-1:0]  area;
    logic [SCORE_W-1:0] lim;
    logic               fend;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } back_state_t;

  function automatic logic [7:0] absdiff(input logic [7:0] x, input logic [7:0] y);
    absdiff = (x > y) ? (x - y) : (y - x);
  endfunction

endpackage

@@ rtl/icd_in_if.sv @@
// Sample input channel of the comb detector (valid/ready plus sample fields).
// Depends on nothing.
`timescale 1ns / 1ps
interface icd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic [1:0] plane;
  logic       plane_end;
  logic       frame_end;
  modport source(output valid, sample, plane, plane_end, frame_end, input ready);
  modport sink(input valid, sample, plane, plane_end, frame_end, output ready);
endinterface

@@ rtl/icd_out_if.sv @@
// Result channel of the comb detector (valid/ready plus result fields).
// Depends on nothing.
`timescale 1ns / 1ps
interface icd_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] first_comb_count;
  logic [24:0] second_comb_count;
  logic [9:0]  score;
  logic        plane_interlaced;
  logic        frame_interlaced;
  logic        frame_done;
  modport source(output valid, first_comb_count, second_comb_count, score,
                 plane_interlaced, frame_interlaced, frame_done, input ready);
  modport sink(input valid, first_comb_count, second_comb_count, score,
               plane_interlaced, frame_interlaced, frame_done, output ready);
endinterface

@@ rtl/icd_cfg_if.sv @@
// Configuration write channel of the comb detector (valid/ready, index, data).
// Depends on nothing.
`timescale 1ns / 1ps
interface icd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [13:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/interlace_comb_detector_top.sv @@
// Top level of the interlace comb detector: wires front, job queue and back together.
// Depends on icd_pkg, the three channel interfaces, icd_front, icd_queue and icd_back.
`timescale 1ns / 1ps
// Usage:
//  in_ch   : one 8-bit sample per item, raster order, plane by plane; plane_end marks the
//            last sample of a plane, frame_end the last of a frame (it also ends the plane).
//  out_ch  : one item per plane with both comb counts, per-mille score and flags.
//  cfg_ch  : register writes (index 0..7), always ready; write only while the block idles.
//  Throughput: one sample item per cycle while the queue has room. The front reads the
//  three line-store RAMs at accept and compares/writes back in the next cycle, with a
//  bypass for same-column items. A plane-end item yields its result after the back's
//  multiply state and a restoring division (one quotient bit per cycle).
//  A four-entry job queue sits between front and back; the front only stalls input when
//  the queue could not take a job, so a stalled receiver halts samples only once four
//  plane jobs wait in the queue behind the one held in the result register. The result
//  is held stable in its register until taken.
//  Reset (rst_n low, synchronous): registers go to defaults, counters and queue clear.
//  Line-store contents are not cleared; within a plane only written entries are read.
module interlace_comb_detector_top (
  input  logic      clk,
  input  logic      rst_n,
  icd_in_if.sink    in_ch,
  icd_cfg_if.sink   cfg_ch,
  icd_out_if.source out_ch
);
  logic                       q_push, q_pop, q_valid;
  icd_pkg::job_t              q_job, q_head;
  logic [icd_pkg::QCNT_W-1:0] q_count;

  icd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch),
    .q_count(q_count), .q_push(q_push), .q_job(q_job));

  icd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(q_job),
    .pop(q_pop), .not_empty(q_valid), .head(q_head), .count(q_count));

  icd_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .out_ch(out_ch));
endmodule

@@ rtl/icd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module icd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/icd_front.sv @@
// Front of the comb detector: config registers, raster counters, line stores, comb counters.
// Depends on icd_pkg, icd_in_if, icd_cfg_if and icd_ram; pushes plane jobs to the queue.
`timescale 1ns / 1ps
module icd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  icd_in_if.sink                        in_ch,
  icd_cfg_if.sink                       cfg_ch,
  input  logic [icd_pkg::QCNT_W-1:0]    q_count,
  output logic                          q_push,
  output icd_pkg::job_t                 q_job
);
  logic [icd_pkg::COL_W-1:0]   row_bytes_r;
  logic [icd_pkg::ROW_W-1:0]   row_count_r;
  logic [7:0]                  luma_eq_r, luma_df_r, chroma_eq_r, chroma_df_r;
  logic [icd_pkg::SCORE_W-1:0] luma_lim_r, chroma_lim_r;

  logic [icd_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [icd_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [icd_pkg::CNT_W-1:0]   first_r, second_r, first_nxt, second_nxt;

  // stage 1 (RAM read data arrives here)
  logic                        s1_valid_r, s1_store_r, s1_cmp_r, s1_end_r, s1_fend_r;
  logic [icd_pkg::ADDR_W-1:0]  s1_addr_r;
  logic [7:0]                  s1_s4_r, s1_eq_r, s1_df_r;
  logic [icd_pkg::AREA_W-1:0]  s1_area_r;
  logic [icd_pkg::SCORE_W-1:0] s1_lim_r;

  logic                        fwd_r, fwd_nxt;
  logic [7:0]                  fwd_a_r, fwd_b_r, fwd_c_r;

  logic                        luma, col_last, is_end, acc, cmp, store;
  logic [icd_pkg::COL_W-1:0]   w, step_w;
  logic [icd_pkg::ROW_W-1:0]   h;
  logic [icd_pkg::AREA_W-1:0]  area;
  logic [7:0]                  ram_a, ram_b, ram_c, va, vb, vc;
  logic                        inc1, inc2;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r  <= icd_pkg::ROW_BYTES_RST;
      row_count_r  <= icd_pkg::ROW_COUNT_RST;
      luma_eq_r    <= icd_pkg::LUMA_EQ_RST;
      luma_df_r    <= icd_pkg::LUMA_DF_RST;
      luma_lim_r   <= icd_pkg::LUMA_LIM_RST;
      chroma_eq_r  <= icd_pkg::CHROMA_EQ_RST;
      chroma_df_r  <= icd_pkg::CHROMA_DF_RST;
      chroma_lim_r <= icd_pkg::CHROMA_LIM_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        icd_pkg::REG_ROW_BYTES:  row_bytes_r  <= cfg_ch.data;
        icd_pkg::REG_ROW_COUNT:  row_count_r  <= cfg_ch.data[icd_pkg::ROW_W-1:0];
        icd_pkg::REG_LUMA_EQ:    luma_eq_r    <= cfg_ch.data[7:0];
        icd_pkg::REG_LUMA_DF:    luma_df_r    <= cfg_ch.data[7:0];
        icd_pkg::REG_LUMA_LIM:   luma_lim_r   <= cfg_ch.data[icd_pkg::SCORE_W-1:0];
        icd_pkg::REG_CHROMA_EQ:  chroma_eq_r  <= cfg_ch.data[7:0];
        icd_pkg::REG_CHROMA_DF:  chroma_df_r  <= cfg_ch.data[7:0];
        icd_pkg::REG_CHROMA_LIM: chroma_lim_r <= cfg_ch.data[icd_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    luma   = (in_ch.plane == 2'd0);
    w      = luma ? row_bytes_r : {1'b0, row_bytes_r[icd_pkg::COL_W-1:1]};
    h      = luma ? row_count_r : {1'b0, row_count_r[icd_pkg::ROW_W-1:1]};
    step_w = (w == '0) ? icd_pkg::COL_W'(1) : w;
    col_last = ({1'b0, col_r} + (icd_pkg::COL_W+1)'(1)) >= {1'b0, step_w};
    is_end = in_ch.plane_end | in_ch.frame_end;
    // room for this item's job and the one possibly still in stage 1
    in_ch.ready = ({1'b0, q_count} + (icd_pkg::QCNT_W+1)'(s1_valid_r & s1_end_r))
                  < (icd_pkg::QCNT_W+1)'(icd_pkg::QDEPTH);
    acc    = in_ch.valid & in_ch.ready;
    store  = ~col_r[icd_pkg::COL_W-1];
    // stored columns only; odd rows from 3 while the pair start stays below height-4
    cmp    = store && (row_r < icd_pkg::ROW_SAT) && (row_r >= icd_pkg::ROW_W'(3)) &&
             row_r[0] && (({1'b0, row_r} + (icd_pkg::ROW_W+1)'(1)) < {1'b0, h});
    area   = icd_pkg::AREA_W'(w) * icd_pkg::AREA_W'(h);

    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (is_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_last) begin
        col_nxt = '0;
        if (row_r < icd_pkg::ROW_SAT) row_nxt = row_r + icd_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + icd_pkg::COL_W'(1);
      end
    end
  end

  icd_ram #(.WIDTH(8), .DEPTH(icd_pkg::MAX_ROW_BYTES)) u_ram_a (
    .clk(clk), .we(s1_valid_r & s1_store_r), .waddr(s1_addr_r), .wdata(vb),
    .re(acc), .raddr(col_r[icd_pkg::ADDR_W-1:0]), .rdata(ram_a));
  icd_ram #(.WIDTH(8), .DEPTH(icd_pkg::MAX_ROW_BYTES)) u_ram_b (
    .clk(clk), .we(s1_valid_r & s1_store_r), .waddr(s1_addr_r), .wdata(vc),
    .re(acc), .raddr(col_r[icd_pkg::ADDR_W-1:0]), .rdata(ram_b));
  icd_ram #(.WIDTH(8), .DEPTH(icd_pkg::MAX_ROW_BYTES)) u_ram_c (
    .clk(clk), .we(s1_valid_r & s1_store_r), .waddr(s1_addr_r), .wdata(s1_s4_r),
    .re(acc), .raddr(col_r[icd_pkg::ADDR_W-1:0]), .rdata(ram_c));

  always_comb begin
    // back-to-back items on the same column: take the data just written
    va = fwd_r ? fwd_a_r : ram_a;
    vb = fwd_r ? fwd_b_r : ram_b;
    vc = fwd_r ? fwd_c_r : ram_c;
    fwd_nxt = acc & store & s1_valid_r & s1_store_r &
              (s1_addr_r == col_r[icd_pkg::ADDR_W-1:0]);
    inc1 = s1_cmp_r && (icd_pkg::absdiff(va, vc) < s1_eq_r) &&
           (icd_pkg::absdiff(va, vb) > s1_df_r);
    inc2 = s1_cmp_r && (icd_pkg::absdiff(vb, s1_s4_r) < s1_eq_r) &&
           (icd_pkg::absdiff(vb, vc) > s1_df_r);
    first_nxt  = (inc1 && first_r != icd_pkg::CNT_MAX) ? first_r + icd_pkg::CNT_W'(1)
                                                        : first_r;
    second_nxt = (inc2 && second_r != icd_pkg::CNT_MAX) ? second_r + icd_pkg::CNT_W'(1)
                                                         : second_r;
    q_push        = s1_valid_r & s1_end_r;
    q_job.first   = first_nxt;
    q_job.second  = second_nxt;
    q_job.area    = s1_area_r;
    q_job.lim     = s1_lim_r;
    q_job.fend    = s1_fend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      first_r    <= '0;
      second_r   <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= acc;
      fwd_r      <= fwd_nxt;
      if (s1_valid_r) begin
        first_r  <= s1_end_r ? '0 : first_nxt;
        second_r <= s1_end_r ? '0 : second_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_a_r <= vb;
    fwd_b_r <= vc;
    fwd_c_r <= s1_s4_r;
    if (acc) begin
      s1_store_r <= store;
      s1_cmp_r   <= cmp;
      s1_end_r   <= is_end;
      s1_fend_r  <= in_ch.frame_end;
      s1_addr_r  <= col_r[icd_pkg::ADDR_W-1:0];
      s1_s4_r    <= in_ch.sample;
      s1_eq_r    <= luma ? luma_eq_r : chroma_eq_r;
      s1_df_r    <= luma ? luma_df_r : chroma_df_r;
      s1_area_r  <= area;
      s1_lim_r   <= luma ? luma_lim_r : chroma_lim_r;
    end
  end
endmodule

@@ rtl/icd_queue.sv @@
// Small FIFO of plane jobs between the front and the back of the comb detector.
// Depends on icd_pkg.
`timescale 1ns / 1ps
module icd_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  icd_pkg::job_t              push_job,
  input  logic                       pop,
  output logic                       not_empty,
  output icd_pkg::job_t              head,
  output logic [icd_pkg::QCNT_W-1:0] count
);
  icd_pkg::job_t               ent_r [icd_pkg::QDEPTH];
  logic [icd_pkg::QPTR_W-1:0]  wp_r, rp_r;
  logic [icd_pkg::QCNT_W-1:0]  cnt_r;

  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rp_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + icd_pkg::QPTR_W'(1);
      if (pop)  rp_r <= rp_r + icd_pkg::QPTR_W'(1);
      cnt_r <= cnt_r + icd_pkg::QCNT_W'(push) - icd_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end
endmodule

@@ rtl/icd_back.sv @@
// Back of the comb detector: per-mille score by restoring division, flags, result register.
// Depends on icd_pkg and icd_out_if; takes jobs from icd_queue.
`timescale 1ns / 1ps
module icd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  icd_pkg::job_t q_head,
  output logic          q_pop,
  icd_out_if.source     out_ch
);
  icd_pkg::back_state_t         state_r, state_nxt;
  icd_pkg::job_t                job_r;
  logic [icd_pkg::NUM_W-1:0]    num_r;
  logic [icd_pkg::AREA_W-1:0]   rem_r;
  logic [5:0]                   cnt_r;
  logic                         any_r;
  logic [icd_pkg::AREA_W:0]     rem_sh;
  logic                         qbit;
  logic [icd_pkg::NUM_W-1:0]    quot;
  logic [icd_pkg::SCORE_W-1:0]  score;
  logic                         flag;
  logic [icd_pkg::SUM_W-1:0]    sum;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    sum    = icd_pkg::SUM_W'(job_r.first) + icd_pkg::SUM_W'(job_r.second);
    rem_sh = {rem_r, num_r[icd_pkg::NUM_W-1]};
    qbit   = rem_sh >= {1'b0, job_r.area};
    quot   = {num_r[icd_pkg::NUM_W-2:0], qbit};
    if (job_r.area == '0) begin
      score = '0;
    end else if (quot > icd_pkg::NUM_W'(icd_pkg::SCORE_MAX)) begin
      score = icd_pkg::SCORE_MAX;
    end else begin
      score = quot[icd_pkg::SCORE_W-1:0];
    end
    flag = score > job_r.lim;
    unique case (state_r)
      icd_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = icd_pkg::BK_MUL;
        end
      end
      icd_pkg::BK_MUL: state_nxt = icd_pkg::BK_DIV;
      icd_pkg::BK_DIV: begin
        if (cnt_r == 6'(icd_pkg::NUM_W - 1)) state_nxt = icd_pkg::BK_OUT;
      end
      icd_pkg::BK_OUT: begin
        if (out_ch.ready) state_nxt = icd_pkg::BK_IDLE;
      end
      default: state_nxt = icd_pkg::BK_IDLE;
    endcase
  end

  assign out_ch.valid = (state_r == icd_pkg::BK_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icd_pkg::BK_IDLE;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == icd_pkg::BK_DIV && cnt_r == 6'(icd_pkg::NUM_W - 1)) begin
        any_r <= job_r.fend ? 1'b0 : (any_r | flag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
    if (state_r == icd_pkg::BK_MUL) begin
      num_r <= icd_pkg::NUM_W'(sum) * icd_pkg::NUM_W'(1000);
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == icd_pkg::BK_DIV) begin
      num_r <= quot;
      rem_r <= qbit ? icd_pkg::AREA_W'(rem_sh - {1'b0, job_r.area})
                    : rem_sh[icd_pkg::AREA_W-1:0];
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'(icd_pkg::NUM_W - 1)) begin
        out_ch.first_comb_count  <= job_r.first;
        out_ch.second_comb_count <= job_r.second;
        out_ch.score             <= score;
        out_ch.plane_interlaced  <= flag;
        out_ch.frame_interlaced  <= any_r | flag;
        out_ch.frame_done        <= job_r.fend;
      end
    end
  end
endmodule
